>>> rtl/imhq_pkg.sv
package imhq_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_W     = 6;
  localparam int PRIO_W   = 32;
  localparam int CNT_W    = 7;
  localparam int FUNC_W   = 3;
  localparam int ENTRY_W  = ID_W + PRIO_W;

  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_RAISE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_LOWER  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [ID_W-1:0]          elem_id;
    logic signed [PRIO_W-1:0] prio_in;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic [ID_W-1:0]          out_id;
    logic signed [PRIO_W-1:0] out_prio;
    logic [CNT_W-1:0]         elem_count;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

endpackage

>>> rtl/imhq_ram.sv
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/indexed_max_heap_queue.sv
// channel | valid     | stall     | payload
// request | req_valid | req_stall | req (func, elem_id, prio_in)
// result  | rsp_valid | rsp_stall | rsp (ok, out_id, out_prio, elem_count)
// A new request is taken only when the last one is done. Each sift level
// costs a read and a compare on the heap RAM's single read port (sift-up:
// one read per level; sift-down: up to two reads per level).
// Reset (rst, synchronous) empties the queue; no clearing pass is needed.
// A pending result beat does not block taking the next request beat.
module indexed_max_heap_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  imhq_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output imhq_pkg::rsp_t  rsp
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_POS    = 12'b000000000010,
    S_OLD    = 12'b000000000100,
    S_TOP    = 12'b000000001000,
    S_LAST   = 12'b000000010000,
    S_UP_RD  = 12'b000000100000,
    S_UP_CMP = 12'b000001000000,
    S_DN_RD  = 12'b000010000000,
    S_DN_L   = 12'b000100000000,
    S_DN_R   = 12'b001000000000,
    S_DONE   = 12'b010000000000,
    S_SPARE  = 12'b100000000000
  } state_t;

  state_t                         state;
  logic [imhq_pkg::FUNC_W-1:0]    op;
  imhq_pkg::entry_t               item;
  imhq_pkg::entry_t               cand;
  logic [imhq_pkg::ID_W-1:0]      pos;
  logic [imhq_pkg::ID_W-1:0]      cand_pos;
  logic                           cand_mv;
  logic [imhq_pkg::CNT_W-1:0]     cnt;
  logic [imhq_pkg::CAPACITY-1:0]  present;
  logic                           r_ok;
  logic [imhq_pkg::ID_W-1:0]      r_id;
  logic signed [imhq_pkg::PRIO_W-1:0] r_prio;

  logic                           h_we, p_we;
  logic [imhq_pkg::ID_W-1:0]      h_waddr, h_raddr, p_waddr, p_raddr;
  imhq_pkg::entry_t               h_wdata, h_rdata;
  logic [imhq_pkg::ID_W-1:0]      p_wdata, p_rdata;

  logic signed [imhq_pkg::PRIO_W-1:0] cmp_a, cmp_b;
  logic                           gt;
  logic [7:0]                     left, right;
  logic                           left_in, right_in;
  logic [imhq_pkg::ID_W-1:0]      parent;
  logic                           accept, dn_decide, dn_move;
  imhq_pkg::entry_t               win;
  logic [imhq_pkg::ID_W-1:0]      win_pos;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign left      = {1'b0, pos, 1'b1};
  assign right     = left + 8'd1;
  assign left_in   = left < {1'b0, cnt};
  assign right_in  = right < {1'b0, cnt};
  assign parent    = (pos - imhq_pkg::ID_W'(1)) >> 1;
  assign gt        = cmp_a > cmp_b;
  assign dn_decide = (state == S_DN_L && !right_in) || (state == S_DN_R);

  imhq_ram #(.WIDTH(imhq_pkg::ENTRY_W), .DEPTH(imhq_pkg::CAPACITY)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  imhq_ram #(.WIDTH(imhq_pkg::ID_W), .DEPTH(imhq_pkg::CAPACITY)) u_slot (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  always_comb begin
    h_raddr = '0;
    p_raddr = req.elem_id;
    cmp_a   = h_rdata.prio;
    cmp_b   = item.prio;
    win     = item;
    win_pos = pos;
    dn_move = 1'b0;
    h_we    = 1'b0;
    h_waddr = pos;
    h_wdata = item;
    p_we    = 1'b0;
    p_waddr = item.id;
    p_wdata = pos;
    case (state)
      S_POS:   h_raddr = p_rdata;
      S_TOP:   h_raddr = imhq_pkg::ID_W'(cnt - imhq_pkg::CNT_W'(1));
      S_UP_RD: h_raddr = parent;
      S_DN_RD: h_raddr = left[imhq_pkg::ID_W-1:0];
      S_DN_L:  h_raddr = right[imhq_pkg::ID_W-1:0];
      default: h_raddr = '0;
    endcase
    case (state)
      S_OLD: begin
        if (op == imhq_pkg::FN_RAISE) begin
          cmp_a = item.prio;
          cmp_b = h_rdata.prio;
        end
      end
      S_UP_CMP: begin
        cmp_a = item.prio;
        cmp_b = h_rdata.prio;
      end
      S_DN_R:  cmp_b = cand.prio;
      default: cmp_b = item.prio;
    endcase
    if (state == S_DN_L) begin
      win     = gt ? h_rdata : item;
      win_pos = gt ? right[imhq_pkg::ID_W-1:0] - imhq_pkg::ID_W'(1) : pos;
      dn_move = gt;
    end else if (state == S_DN_R) begin
      win     = gt ? h_rdata : cand;
      win_pos = gt ? right[imhq_pkg::ID_W-1:0] : cand_pos;
      dn_move = gt || cand_mv;
    end
    // final placement of the moving item, or one hole shift
    if ((state == S_UP_RD && pos == '0) || (state == S_DN_RD && !left_in) ||
        (state == S_UP_CMP && !gt) || (dn_decide && !dn_move)) begin
      h_we = 1'b1;
      p_we = 1'b1;
    end else if (state == S_UP_CMP) begin
      h_we    = 1'b1;
      h_wdata = h_rdata;
      p_we    = 1'b1;
      p_waddr = h_rdata.id;
    end else if (dn_decide) begin
      h_we    = 1'b1;
      h_wdata = win;
      p_we    = 1'b1;
      p_waddr = win.id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      present   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op     <= req.func;
            item   <= '{id: req.elem_id, prio: req.prio_in};
            r_prio <= '0;
            case (req.func)
              imhq_pkg::FN_INSERT: begin
                r_id <= req.elem_id;
                if (!present[req.elem_id] &&
                    cnt != imhq_pkg::CNT_W'(imhq_pkg::CAPACITY)) begin
                  present[req.elem_id] <= 1'b1;
                  pos   <= cnt[imhq_pkg::ID_W-1:0];
                  cnt   <= cnt + imhq_pkg::CNT_W'(1);
                  r_ok  <= 1'b1;
                  state <= S_UP_RD;
                end else begin
                  r_ok  <= 1'b0;
                  state <= S_DONE;
                end
              end
              imhq_pkg::FN_RAISE, imhq_pkg::FN_LOWER, imhq_pkg::FN_QUERY: begin
                r_id  <= req.elem_id;
                r_ok  <= 1'b0;
                state <= present[req.elem_id] ? S_POS : S_DONE;
              end
              imhq_pkg::FN_REMOVE: begin
                r_id  <= '0;
                r_ok  <= 1'b0;
                state <= (cnt != '0) ? S_TOP : S_DONE;
              end
              default: begin
                r_id  <= req.elem_id;
                r_ok  <= 1'b0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_POS: begin
          pos   <= p_rdata;
          state <= S_OLD;
        end
        S_OLD: begin
          if (op == imhq_pkg::FN_QUERY) begin
            r_ok   <= 1'b1;
            r_prio <= h_rdata.prio;
            state  <= S_DONE;
          end else if (gt) begin
            r_ok  <= 1'b1;
            state <= (op == imhq_pkg::FN_RAISE) ? S_UP_RD : S_DN_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_TOP: begin
          r_ok   <= 1'b1;
          r_id   <= h_rdata.id;
          r_prio <= h_rdata.prio;
          present[h_rdata.id] <= 1'b0;
          cnt    <= cnt - imhq_pkg::CNT_W'(1);
          state  <= (cnt == imhq_pkg::CNT_W'(1)) ? S_DONE : S_LAST;
        end
        S_LAST: begin
          item  <= h_rdata;
          pos   <= '0;
          state <= S_DN_RD;
        end
        S_UP_RD: state <= (pos == '0) ? S_DONE : S_UP_CMP;
        S_UP_CMP: begin
          if (gt) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_RD: state <= left_in ? S_DN_L : S_DONE;
        S_DN_L: begin
          if (right_in) begin
            cand     <= win;
            cand_pos <= win_pos;
            cand_mv  <= dn_move;
            state    <= S_DN_R;
          end else if (dn_move) begin
            pos   <= win_pos;
            state <= S_DN_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_R: begin
          if (dn_move) begin
            pos   <= win_pos;
            state <= S_DN_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp <= '{ok: r_ok, out_id: r_id, out_prio: r_prio, elem_count: cnt};
    end
  end

endmodule

>>> bench/imhq_checker.sv
`timescale 1ns / 100ps

module imhq_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  imhq_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  imhq_pkg::rsp_t rsp,
  output int             fail_count,
  output int             pending
);

  logic [imhq_pkg::ID_W-1:0]          slot_id [imhq_pkg::CAPACITY];
  logic [imhq_pkg::ID_W-1:0]          id_slot [imhq_pkg::CAPACITY];
  logic signed [imhq_pkg::PRIO_W-1:0] id_prio [imhq_pkg::CAPACITY];
  logic                               in_heap [imhq_pkg::CAPACITY];
  int                                 heap_size;
  imhq_pkg::rsp_t                     want_q [$];

  assign pending = want_q.size();

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void put(input int slot, input logic [imhq_pkg::ID_W-1:0] id);
    slot_id[slot] = id;
    id_slot[id] = slot[imhq_pkg::ID_W-1:0];
  endfunction

  function automatic void bubble_up(input logic [imhq_pkg::ID_W-1:0] id);
    int pos;
    int par;
    logic [imhq_pkg::ID_W-1:0] pid;
    pos = int'(id_slot[id]);
    while (pos > 0) begin
      par = (pos - 1) / 2;
      pid = slot_id[par];
      if (!(id_prio[pid] < id_prio[id])) break;
      put(pos, pid);
      put(par, id);
      pos = par;
    end
  endfunction

  function automatic void bubble_down(input logic [imhq_pkg::ID_W-1:0] id);
    int pos;
    int lc;
    int rc;
    int best;
    logic signed [imhq_pkg::PRIO_W-1:0] bp;
    pos = int'(id_slot[id]);
    while (pos < heap_size) begin
      lc = 2 * pos + 1;
      rc = lc + 1;
      best = pos;
      bp = id_prio[id];
      if (lc < heap_size && id_prio[slot_id[lc]] > bp) begin
        best = lc;
        bp = id_prio[slot_id[lc]];
      end
      if (rc < heap_size && id_prio[slot_id[rc]] > bp) best = rc;
      if (best == pos) break;
      put(pos, slot_id[best]);
      put(best, id);
      pos = best;
    end
  endfunction

  function automatic imhq_pkg::rsp_t apply_op(input imhq_pkg::req_t r);
    imhq_pkg::rsp_t o;
    logic [imhq_pkg::ID_W-1:0] id;
    logic [imhq_pkg::ID_W-1:0] top;
    logic [imhq_pkg::ID_W-1:0] last;
    id = r.elem_id;
    o = '0;
    o.out_id = id;
    case (r.func)
      imhq_pkg::FN_INSERT: begin
        if (!in_heap[id] && heap_size < imhq_pkg::CAPACITY) begin
          in_heap[id] = 1'b1;
          id_prio[id] = r.prio_in;
          put(heap_size, id);
          heap_size++;
          bubble_up(id);
          o.ok = 1'b1;
        end
      end
      imhq_pkg::FN_RAISE: begin
        if (in_heap[id] && id_prio[id] < r.prio_in) begin
          id_prio[id] = r.prio_in;
          bubble_up(id);
          o.ok = 1'b1;
        end
      end
      imhq_pkg::FN_LOWER: begin
        if (in_heap[id] && id_prio[id] > r.prio_in) begin
          id_prio[id] = r.prio_in;
          bubble_down(id);
          o.ok = 1'b1;
        end
      end
      imhq_pkg::FN_REMOVE: begin
        if (heap_size == 0) begin
          o.out_id = '0;
        end else begin
          top = slot_id[0];
          last = slot_id[heap_size-1];
          o.out_id = top;
          o.out_prio = id_prio[top];
          in_heap[top] = 1'b0;
          heap_size--;
          if (heap_size > 0) begin
            put(0, last);
            bubble_down(last);
          end
          o.ok = 1'b1;
        end
      end
      imhq_pkg::FN_QUERY: begin
        if (in_heap[id]) begin
          o.out_prio = id_prio[id];
          o.ok = 1'b1;
        end
      end
      default: ;
    endcase
    o.elem_count = heap_size[imhq_pkg::CNT_W-1:0];
    return o;
  endfunction

  always @(posedge clk) begin
    imhq_pkg::rsp_t w;
    if (rst) begin
      for (int i = 0; i < imhq_pkg::CAPACITY; i++) in_heap[i] = 1'b0;
      heap_size = 0;
      want_q.delete();
      fail_count = 0;
    end else begin
      if (req_valid && !req_stall) want_q.push_back(apply_op(req));
      if (rsp_valid && !rsp_stall) begin
        if (want_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          w = want_q.pop_front();
          if (rsp.ok !== w.ok)
            report($sformatf("ok %b want %b", rsp.ok, w.ok));
          if (rsp.out_id !== w.out_id)
            report($sformatf("out_id %0d want %0d", rsp.out_id, w.out_id));
          if (rsp.out_prio !== w.out_prio)
            report($sformatf("out_prio %h want %h", rsp.out_prio, w.out_prio));
          if (rsp.elem_count !== w.elem_count)
            report($sformatf("elem_count %0d want %0d", rsp.elem_count, w.elem_count));
        end
      end
    end
  end
endmodule

>>> bench/tb_indexed_max_heap_queue.sv
`timescale 1ns / 100ps

module tb_indexed_max_heap_queue;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  imhq_pkg::req_t req;
  logic           rsp_valid;
  logic           rsp_stall;
  imhq_pkg::rsp_t rsp;
  int             fail_count;
  int             pending;

  indexed_max_heap_queue dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  imhq_checker chk (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [imhq_pkg::PRIO_W-1:0] rand_prio();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 6)) - 32'd3);
      default: return $signed(32'($urandom));
    endcase
  endfunction

  // random stall on the result side
  initial begin
    rsp_stall = 1'b1;
    @(posedge clk);
    forever begin
      rsp_stall <= ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : 1) @(posedge clk);
    end
  end

  task automatic send(input logic [imhq_pkg::FUNC_W-1:0] f,
                      input logic [imhq_pkg::ID_W-1:0] id,
                      input logic signed [imhq_pkg::PRIO_W-1:0] p);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{func: f, elem_id: id, prio_in: p};
    do @(posedge clk); while (req_stall);
  endtask

  initial begin
    int pick;
    logic [imhq_pkg::FUNC_W-1:0] f;
    logic [imhq_pkg::ID_W-1:0] id;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send(imhq_pkg::FN_REMOVE, 6'd5, 32'sd0);
    send(imhq_pkg::FN_QUERY, 6'd0, 32'sd0);
    send(imhq_pkg::FN_RAISE, 6'd1, 32'sd9);
    send(imhq_pkg::FN_LOWER, 6'd1, 32'sd9);
    send(imhq_pkg::FN_INSERT, 6'd0, 32'sh80000000);
    send(imhq_pkg::FN_INSERT, 6'd63, 32'sh7fffffff);
    send(imhq_pkg::FN_INSERT, 6'd7, 32'sd100);
    send(imhq_pkg::FN_INSERT, 6'd8, 32'sd100);
    send(imhq_pkg::FN_INSERT, 6'd7, 32'sd5);
    send(imhq_pkg::FN_RAISE, 6'd8, 32'sd100);
    send(imhq_pkg::FN_RAISE, 6'd8, 32'sd101);
    send(imhq_pkg::FN_LOWER, 6'd63, 32'sh7fffffff);
    send(imhq_pkg::FN_LOWER, 6'd63, 32'sh80000000);
    send(imhq_pkg::FN_QUERY, 6'd63, 32'sd0);
    send(3'd5, 6'd42, 32'sd1);
    send(3'd6, 6'd21, 32'sd1);
    send(3'd7, 6'd63, 32'shffffffff);
    for (int i = 0; i < 6; i++) send(imhq_pkg::FN_REMOVE, 6'($urandom), 32'sd0);

    for (int n = 0; n < 1360; n++) begin
      if (n % 400 == 0) begin
        for (int k = 0; k < 64; k++) send(imhq_pkg::FN_INSERT, k[5:0], rand_prio());
      end
      pick = $urandom_range(0, 99);
      f = pick < 35 ? imhq_pkg::FN_INSERT : pick < 50 ? imhq_pkg::FN_RAISE :
          pick < 65 ? imhq_pkg::FN_LOWER : pick < 87 ? imhq_pkg::FN_REMOVE :
          pick < 97 ? imhq_pkg::FN_QUERY : 3'($urandom_range(5, 7));
      id = 6'($urandom);
      send(f, id, rand_prio());
    end
    req_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_indexed_max_heap_queue OK");
    end else begin
      $display("tb_indexed_max_heap_queue NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_indexed_max_heap_queue NOT OK");
    $finish;
  end
endmodule

>>> indexed_max_heap_queue.f
rtl/imhq_pkg.sv
rtl/imhq_ram.sv
rtl/indexed_max_heap_queue.sv
bench/imhq_checker.sv
bench/tb_indexed_max_heap_queue.sv
